// ----- rtl/trilinear_grid_interpolator_top_defines.svh -----
// Assertion macros used by the trilinear grid interpolator back end
`ifndef TRILINEAR_GRID_INTERPOLATOR_TOP_DEFINES_SVH
`define TRILINEAR_GRID_INTERPOLATOR_TOP_DEFINES_SVH

// same-cycle implication on clk, disabled during rst
`define TGI_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, disabled during rst
`define TGI_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tgi_pkg.sv -----
// Shared types and constants for the trilinear grid interpolator
package tgi_pkg;

  localparam int POS_BITS    = 4;
  localparam int SIZE_BITS   = 5;
  localparam int FRAC_W      = 8;
  localparam int SAMPLE_W    = 32;
  localparam int RESULT_W    = 32;
  localparam int WGT_W       = FRAC_W + 1;
  localparam int WXY_W       = 2 * WGT_W;
  localparam int W_W         = 3 * WGT_W;
  localparam int PROD_W      = SAMPLE_W + W_W + 1;
  localparam int SHIFT       = 3 * FRAC_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  localparam logic ACT_WRITE = 1'b0;

  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_QUERY,
    CMD_ERROR
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_DRAIN
  } back_state_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0] sx;
    logic [SIZE_BITS-1:0] sy;
    logic [SIZE_BITS-1:0] sz;
  } grid_size_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [POS_BITS-1:0]   lo_x;
    logic [POS_BITS-1:0]   lo_y;
    logic [POS_BITS-1:0]   lo_z;
    logic [SIZE_BITS-1:0]  hi_x;
    logic [SIZE_BITS-1:0]  hi_y;
    logic [SIZE_BITS-1:0]  hi_z;
    logic [FRAC_W-1:0]     frac_x;
    logic [FRAC_W-1:0]     frac_y;
    logic [FRAC_W-1:0]     frac_z;
    logic [SAMPLE_W-1:0]   sample;
  } cmd_t;

endpackage

// ----- rtl/tgi_front.sv -----
// Front end: range check, upper-corner clamp and command build
module tgi_front (
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           action,
  input  logic [tgi_pkg::POS_BITS-1:0]   pos_x,
  input  logic [tgi_pkg::POS_BITS-1:0]   pos_y,
  input  logic [tgi_pkg::POS_BITS-1:0]   pos_z,
  input  logic [tgi_pkg::FRAC_W-1:0]     frac_x,
  input  logic [tgi_pkg::FRAC_W-1:0]     frac_y,
  input  logic [tgi_pkg::FRAC_W-1:0]     frac_z,
  input  logic [tgi_pkg::SAMPLE_W-1:0]   sample_value,
  input  tgi_pkg::grid_size_t            size,
  output logic                           push_valid,
  output tgi_pkg::cmd_t                  push_cmd,
  input  logic                           push_ready
);

  localparam int SW = tgi_pkg::SIZE_BITS;

  logic [SW-1:0] px, py, pz;
  logic [SW-1:0] nx, ny, nz;
  logic          in_range;

  assign px = SW'(pos_x);
  assign py = SW'(pos_y);
  assign pz = SW'(pos_z);
  assign nx = px + SW'(1);
  assign ny = py + SW'(1);
  assign nz = pz + SW'(1);

  assign in_range = (px < size.sx) && (py < size.sy) && (pz < size.sz);

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_cmd.lo_x   = pos_x;
    push_cmd.lo_y   = pos_y;
    push_cmd.lo_z   = pos_z;
    // upper corner clamps to the last grid point on each axis
    push_cmd.hi_x   = (nx < size.sx) ? nx : px;
    push_cmd.hi_y   = (ny < size.sy) ? ny : py;
    push_cmd.hi_z   = (nz < size.sz) ? nz : pz;
    push_cmd.frac_x = frac_x;
    push_cmd.frac_y = frac_y;
    push_cmd.frac_z = frac_z;
    push_cmd.sample = sample_value;
    priority if (!in_range) begin
      push_cmd.kind = tgi_pkg::CMD_ERROR;
    end else if (action == tgi_pkg::ACT_WRITE) begin
      push_cmd.kind = tgi_pkg::CMD_WRITE;
    end else begin
      push_cmd.kind = tgi_pkg::CMD_QUERY;
    end
  end

endmodule

// ----- rtl/tgi_queue.sv -----
// Short command queue between front and back end
module tgi_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  tgi_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop,
  output tgi_pkg::cmd_t pop_cmd
);

  localparam int PW = tgi_pkg::QPTR_W;

  tgi_pkg::cmd_t slots [tgi_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0]   count;
  logic          push_fire;

  assign push_ready = (count != (PW+1)'(tgi_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push_fire  = push_valid && push_ready;
  assign pop_cmd    = slots[rptr];

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wptr] <= push_cmd;
    end
  end

  // depth is a power of two, pointers wrap on their own
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push_fire) begin
        wptr <= wptr + PW'(1);
      end
      if (pop) begin
        rptr <= rptr + PW'(1);
      end
      unique case ({push_fire, pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/tgi_back.sv -----
// Back end: grid memory, corner sequencer, weight and MAC pipeline, output register
`include "trilinear_grid_interpolator_top_defines.svh"

module tgi_back #(
  parameter int MAX_DIM = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tgi_pkg::grid_size_t            size,
  input  logic                           cmd_valid,
  input  tgi_pkg::cmd_t                  cmd,
  output logic                           cmd_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           status,
  output logic [tgi_pkg::RESULT_W-1:0]   result_value
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int AW     = $clog2(DEPTH);
  localparam int LIN_W  = (AW > 16) ? AW : 16;
  localparam int SW     = tgi_pkg::SIZE_BITS;
  localparam int WGT_W  = tgi_pkg::WGT_W;
  localparam int WXY_W  = tgi_pkg::WXY_W;
  localparam int W_W    = tgi_pkg::W_W;
  localparam int PROD_W = tgi_pkg::PROD_W;
  localparam int DW     = tgi_pkg::SAMPLE_W;
  localparam int RW     = tgi_pkg::RESULT_W;
  localparam int SHIFT  = tgi_pkg::SHIFT;
  localparam logic [WGT_W-1:0] ONE = WGT_W'(1) << tgi_pkg::FRAC_W;

  tgi_pkg::back_state_t state, state_next;
  tgi_pkg::cmd_t        cur;

  logic          out_free;
  logic          mem_we;
  logic          issue;
  logic [2:0]    corner;

  logic [2*SW-1:0]  stride_x;
  logic [SW-1:0]    ax, ay, az;
  logic [3*SW-1:0]  term_x;
  logic [2*SW-1:0]  term_y;
  logic [LIN_W-1:0] lin;
  logic [AW-1:0]    addr;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata;

  logic [WGT_W-1:0] wx, wy, wz;
  logic [WXY_W-1:0] wxy_reg;
  logic [WGT_W-1:0] wz_reg;
  logic [W_W-1:0]   w_comb, w_reg;
  logic signed [DW-1:0]     data_reg;
  logic signed [PROD_W-1:0] prod_reg, acc, acc_next;

  logic s1_vld, s1_first, s1_last;
  logic s2_vld, s2_first, s2_last;
  logic s3_vld, s3_first, s3_last;

  assign out_free = !out_valid || out_ready;

  // ---- sequencer ----
  always_comb begin
    state_next = state;
    unique case (state)
      tgi_pkg::BK_IDLE: begin
        if (cmd_valid && out_free && cmd.kind == tgi_pkg::CMD_QUERY) begin
          state_next = tgi_pkg::BK_ISSUE;
        end
      end
      tgi_pkg::BK_ISSUE: begin
        if (corner == 3'd7) begin
          state_next = tgi_pkg::BK_DRAIN;
        end
      end
      tgi_pkg::BK_DRAIN: begin
        if (s3_vld && s3_last) begin
          state_next = tgi_pkg::BK_IDLE;
        end
      end
      default: state_next = tgi_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = 1'b0;
    mem_we  = 1'b0;
    issue   = 1'b0;
    unique case (state)
      tgi_pkg::BK_IDLE: begin
        cmd_pop = cmd_valid && out_free;
        mem_we  = cmd_valid && out_free && cmd.kind == tgi_pkg::CMD_WRITE;
      end
      tgi_pkg::BK_ISSUE: issue = 1'b1;
      tgi_pkg::BK_DRAIN: issue = 1'b0;
      default:           issue = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= tgi_pkg::BK_IDLE;
      corner <= '0;
    end else begin
      state <= state_next;
      if (issue) begin
        corner <= corner + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
  end

  // ---- address: x*(sy*sz) + y*sz + z ----
  always_ff @(posedge clk) begin
    stride_x <= size.sy * size.sz;
  end

  assign ax = issue ? (corner[2] ? cur.hi_x : SW'(cur.lo_x)) : SW'(cmd.lo_x);
  assign ay = issue ? (corner[1] ? cur.hi_y : SW'(cur.lo_y)) : SW'(cmd.lo_y);
  assign az = issue ? (corner[0] ? cur.hi_z : SW'(cur.lo_z)) : SW'(cmd.lo_z);

  assign term_x = ax * stride_x;
  assign term_y = ay * size.sz;
  assign lin    = LIN_W'(term_x) + LIN_W'(term_y) + LIN_W'(az);
  assign addr   = lin[AW-1:0];

  // single-port grid memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= cmd.sample;
    end
    rdata <= mem[addr];
  end

  // ---- weights: f for the upper corner, 1-f for the lower ----
  assign wx = corner[2] ? WGT_W'(cur.frac_x) : ONE - WGT_W'(cur.frac_x);
  assign wy = corner[1] ? WGT_W'(cur.frac_y) : ONE - WGT_W'(cur.frac_y);
  assign wz = corner[0] ? WGT_W'(cur.frac_z) : ONE - WGT_W'(cur.frac_z);

  assign w_comb   = W_W'(wxy_reg) * W_W'(wz_reg);
  assign acc_next = (s3_first ? '0 : acc) + prod_reg;

  // stage 1: read issued, wx*wy
  // stage 2: full weight; zero-weight corners contribute nothing
  // stage 3: sample * weight
  // stage 4: accumulate
  always_ff @(posedge clk) begin
    wxy_reg  <= wx * wy;
    wz_reg   <= wz;
    s1_first <= (corner == 3'd0);
    s1_last  <= (corner == 3'd7);
    w_reg    <= w_comb;
    data_reg <= (w_comb == '0) ? '0 : rdata;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    prod_reg <= data_reg * $signed({1'b0, w_reg});
    s3_first <= s2_first;
    s3_last  <= s2_last;
    if (s3_vld) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else begin
      s1_vld <= issue;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      priority if (s3_vld && s3_last) begin
        out_valid    <= 1'b1;
        status       <= tgi_pkg::STATUS_OK;
        result_value <= acc_next[SHIFT+RW-1:SHIFT];
      end else if (cmd_pop && cmd.kind != tgi_pkg::CMD_QUERY) begin
        out_valid    <= 1'b1;
        status       <= (cmd.kind == tgi_pkg::CMD_ERROR) ? tgi_pkg::STATUS_RANGE
                                                         : tgi_pkg::STATUS_OK;
        result_value <= '0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `TGI_ASSERT_SAME(a_finish_out_empty, s3_vld && s3_last, !out_valid, "query result overwrites pending output")
  `TGI_ASSERT_SAME(a_write_pipe_empty, mem_we, !s1_vld && !s2_vld && !s3_vld, "grid write while corner pipeline busy")
  `TGI_ASSERT_NEXT(a_drain_after_last, state == tgi_pkg::BK_ISSUE && corner == 3'd7, state == tgi_pkg::BK_DRAIN && s1_vld && s1_last, "last corner not followed by drain")

endmodule

// ----- rtl/trilinear_grid_interpolator_top.sv -----
// Write/error transactions pass through the command queue and output register to out_valid;
// one write/error per cycle while out_ready is high and no query is active. Queries do not
// overlap: eight corner reads on the single grid memory port, then the 4-stage MAC drain.
// A 2-deep command queue lets the input side keep taking transactions while the back waits.
// Reset (rst, synchronous, active high): sizes return to 16, queue and pipeline empty.
// Grid memory is not cleared by reset; entries are defined once written.
module trilinear_grid_interpolator_top #(
  parameter int MAX_DIM = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tgi_pkg::PADDR_W-1:0]       paddr,
  input  logic [tgi_pkg::PDATA_W-1:0]       pwdata,
  output logic [tgi_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready,
  // input transactions
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              action,
  input  logic [tgi_pkg::POS_BITS-1:0]      pos_x,
  input  logic [tgi_pkg::POS_BITS-1:0]      pos_y,
  input  logic [tgi_pkg::POS_BITS-1:0]      pos_z,
  input  logic [tgi_pkg::FRAC_W-1:0]        frac_x,
  input  logic [tgi_pkg::FRAC_W-1:0]        frac_y,
  input  logic [tgi_pkg::FRAC_W-1:0]        frac_z,
  input  logic [tgi_pkg::SAMPLE_W-1:0]      sample_value,
  // result transactions
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              status,
  output logic [tgi_pkg::RESULT_W-1:0]      result_value
);

  localparam int SW = tgi_pkg::SIZE_BITS;
  localparam int DW = tgi_pkg::PDATA_W;

  // Size registers as written; the effective size saturates at MAX_DIM.
  logic [SW-1:0] size_x, size_y, size_z;
  logic [1:0]    reg_idx;
  logic          cfg_write;

  tgi_pkg::grid_size_t size_eff;

  logic          push_valid, push_ready;
  tgi_pkg::cmd_t push_cmd;
  logic          q_valid, q_pop;
  tgi_pkg::cmd_t q_cmd;

  // ---- configuration port ----
  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SW'(16);
      size_y <= SW'(16);
      size_z <= SW'(16);
    end else if (cfg_write) begin
      unique case (reg_idx)
        tgi_pkg::REG_SIZE_X: size_x <= pwdata[SW-1:0];
        tgi_pkg::REG_SIZE_Y: size_y <= pwdata[SW-1:0];
        tgi_pkg::REG_SIZE_Z: size_z <= pwdata[SW-1:0];
        default:             size_x <= size_x;  // unmapped address, ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tgi_pkg::REG_SIZE_X: prdata = DW'(size_x);
      tgi_pkg::REG_SIZE_Y: prdata = DW'(size_y);
      tgi_pkg::REG_SIZE_Z: prdata = DW'(size_z);
      default:             prdata = '0;
    endcase
  end

  // A size of zero leaves every position out of range through the front check.
  always_comb begin
    size_eff.sx = (int'(size_x) > MAX_DIM) ? SW'(MAX_DIM) : size_x;
    size_eff.sy = (int'(size_y) > MAX_DIM) ? SW'(MAX_DIM) : size_y;
    size_eff.sz = (int'(size_z) > MAX_DIM) ? SW'(MAX_DIM) : size_z;
  end

  // ---- front: classify and clamp ----
  tgi_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .frac_x       (frac_x),
    .frac_y       (frac_y),
    .frac_z       (frac_z),
    .sample_value (sample_value),
    .size         (size_eff),
    .push_valid   (push_valid),
    .push_cmd     (push_cmd),
    .push_ready   (push_ready)
  );

  // ---- decoupling queue ----
  tgi_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  // ---- back: memory, corner walk, MAC, result register ----
  tgi_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .size         (size_eff),
    .cmd_valid    (q_valid),
    .cmd          (q_cmd),
    .cmd_pop      (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .result_value (result_value)
  );

endmodule
